// ===== hw/rtl/fletcher_checksum_mixed_core_defines.svh =====
// ----------------------------------------------------------------------------
// Fletcher checksum core: assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef FLETCHER_CHECKSUM_MIXED_CORE_DEFINES_SVH
`define FLETCHER_CHECKSUM_MIXED_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FCM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fletcher core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define FCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fletcher core: next-cycle check failed");

`endif

// ===== hw/rtl/fcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Fletcher checksum core package
// Job record, finalizer states and mixing constants shared by the core.
// ----------------------------------------------------------------------------
package fcm_pkg;

    // Default depth of the queue between accumulator and finalizer
    localparam int unsigned QUEUE_DEPTH = 2;

    // Mixing constants
    localparam logic [31:0] STAMP_MULT = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MULT1  = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_MULT2  = 32'hC2B2_AE35;
    localparam int unsigned MIX_SHIFT1 = 13;
    localparam int unsigned MIX_SHIFT2 = 16;

    // One finished message handed to the finalizer
    typedef struct packed {
        logic [31:0] sums;   // {high_sum, low_sum}
        logic [31:0] stamp;
    } fcm_job_t;

    // Finalizer sequencer states
    typedef enum logic [2:0] {
        FCM_IDLE,
        FCM_STAMP,
        FCM_MIX1,
        FCM_MIX2,
        FCM_OUT
    } fcm_state_t;

endpackage

// ===== hw/rtl/fcm_queue.sv =====
// ----------------------------------------------------------------------------
// Fletcher checksum job queue
// Small register FIFO that decouples the accumulator from the finalizer.
// ----------------------------------------------------------------------------
`include "fletcher_checksum_mixed_core_defines.svh"

module fcm_queue #(
    parameter int unsigned DEPTH = fcm_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  fcm_pkg::fcm_job_t push_job,
    output logic             pop_valid,
    input  logic             pop_ready,
    output fcm_pkg::fcm_job_t pop_job
);
    import fcm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fcm_job_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `FCM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `FCM_ASSERT_NEXT(a_pop_only_drains, aclk, aresetn, pop_fire && !push_fire,
        count_reg == $past(count_reg) - 1'b1)
    `FCM_ASSERT_NEXT(a_push_only_fills, aclk, aresetn, push_fire && !pop_fire,
        count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hw/rtl/fcm_front.sv =====
// ----------------------------------------------------------------------------
// Fletcher checksum accumulator
// Takes at most one word per transaction, keeps the two end-around-carry
// sums and queues a job for the finalizer at the end of each message.
// ----------------------------------------------------------------------------
`include "fletcher_checksum_mixed_core_defines.svh"

module fcm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       in_word,
    input  logic              in_word_valid,
    input  logic              in_last,
    input  logic [31:0]       in_stamp,
    output logic              job_valid,
    input  logic              job_ready,
    output fcm_pkg::fcm_job_t job
);
    import fcm_pkg::*;

    logic [15:0] low_sum_reg, low_sum_next;
    logic [15:0] high_sum_reg, high_sum_next;
    logic [16:0] low_raw, high_raw;
    logic [15:0] low_fold, high_fold;
    logic [15:0] low_upd, high_upd;
    logic        accept;

    // Stall everything while the queue is full
    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = in_valid && in_last;

    // End-around-carry sums, low sum feeds the high sum
    always_comb begin
        low_raw   = {1'b0, low_sum_reg} + {1'b0, in_word};
        low_fold  = low_raw[15:0] + {15'd0, low_raw[16]};
        low_upd   = in_word_valid ? low_fold : low_sum_reg;
        high_raw  = {1'b0, high_sum_reg} + {1'b0, low_upd};
        high_fold = high_raw[15:0] + {15'd0, high_raw[16]};
        high_upd  = in_word_valid ? high_fold : high_sum_reg;

        job.sums  = {high_upd, low_upd};
        job.stamp = in_stamp;

        low_sum_next  = low_sum_reg;
        high_sum_next = high_sum_reg;
        if (accept) begin
            low_sum_next  = in_last ? 16'd0 : low_upd;
            high_sum_next = in_last ? 16'd0 : high_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_sum_reg  <= 16'd0;
            high_sum_reg <= 16'd0;
        end else begin
            low_sum_reg  <= low_sum_next;
            high_sum_reg <= high_sum_next;
        end
    end

    `FCM_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, accept && in_last,
        low_sum_reg == 16'd0 && high_sum_reg == 16'd0)
    `FCM_ASSERT_NEXT(a_idle_item_holds, aclk, aresetn, accept && !in_last && !in_word_valid,
        $stable(low_sum_reg) && $stable(high_sum_reg))
    `FCM_ASSERT_NOW(a_fold_in_range, aclk, aresetn, in_word_valid && low_raw[16],
        low_fold != 16'hFFFF || low_raw[15:0] == 16'hFFFE)

endmodule

// ===== hw/rtl/fcm_back.sv =====
// ----------------------------------------------------------------------------
// Fletcher checksum finalizer
// Applies the stamp mix and the two-multiply avalanche to one queued job at
// a time and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "fletcher_checksum_mixed_core_defines.svh"

module fcm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  fcm_pkg::fcm_job_t job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_checksum
);
    import fcm_pkg::*;

    fcm_state_t  state_reg, state_next;
    logic [31:0] sums_reg, sums_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [31:0] product;
    logic [31:0] mul_a, mul_b;
    logic        out_busy;

    assign out_valid    = out_valid_reg;
    assign out_checksum = out_data_reg;
    assign out_busy     = out_valid_reg && !out_ready;

    // Single shared 32x32 multiplier, low half kept
    assign product = mul_a * mul_b;

    // Sequencer: at most one multiply per step
    always_comb begin
        state_next     = state_reg;
        sums_next      = sums_reg;
        stamp_next     = stamp_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        job_ready      = 1'b0;
        mul_a          = stamp_reg;
        mul_b          = STAMP_MULT;
        unique case (state_reg)
            FCM_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    sums_next  = job.sums;
                    stamp_next = job.stamp;
                    state_next = FCM_STAMP;
                end
            end
            FCM_STAMP: begin
                acc_next   = sums_reg ^ product;
                state_next = FCM_MIX1;
            end
            FCM_MIX1: begin
                mul_a      = acc_reg;
                mul_b      = MIX_MULT1;
                acc_next   = product;
                state_next = FCM_MIX2;
            end
            FCM_MIX2: begin
                mul_a      = acc_reg ^ (acc_reg >> MIX_SHIFT1);
                mul_b      = MIX_MULT2;
                acc_next   = product;
                state_next = FCM_OUT;
            end
            FCM_OUT: begin
                if (!out_busy) begin
                    out_data_next  = acc_reg ^ (acc_reg >> MIX_SHIFT2);
                    out_valid_next = 1'b1;
                    state_next     = FCM_IDLE;
                end
            end
            default: begin
                state_next = FCM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FCM_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        sums_reg     <= sums_next;
        stamp_reg    <= stamp_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    `FCM_ASSERT_NEXT(a_out_loads, aclk, aresetn, state_reg == FCM_OUT && !out_busy,
        out_valid_reg && state_reg == FCM_IDLE)
    `FCM_ASSERT_NEXT(a_pop_starts, aclk, aresetn, state_reg == FCM_IDLE && job_valid,
        state_reg == FCM_STAMP)
    `FCM_ASSERT_NOW(a_pop_only_idle, aclk, aresetn, job_ready, state_reg == FCM_IDLE)

endmodule

// ===== hw/rtl/fletcher_checksum_mixed_core.sv =====
// A closing word is pushed into the job queue; the finalizer pops one message
// at a time and runs stamp multiply, two mix multiplies and output load on one
// multiplier. The input takes one word per cycle while the queue has room.
// Input stalls only while the job queue (QUEUE_DEPTH entries) is full.
// Reset: aresetn low for one edge clears both sums, the queue and the output.
// ----------------------------------------------------------------------------
// Fletcher checksum core, top level
// Fletcher-32 style accumulator with stamp mix and a finalizer using the fmix32 constants.
// ----------------------------------------------------------------------------
module fletcher_checksum_mixed_core #(
    parameter int unsigned QUEUE_DEPTH = fcm_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] word, [47:16] stamp
    input  logic        s_tuser,   // [0] word_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] checksum
);
    import fcm_pkg::*;

    fcm_job_t push_job, pop_job;
    logic     push_valid, push_ready;
    logic     pop_valid, pop_ready;

    // Accumulator
    fcm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_word       (s_tdata[15:0]),
        .in_word_valid (s_tuser),
        .in_last       (s_tlast),
        .in_stamp      (s_tdata[47:16]),
        .job_valid     (push_valid),
        .job_ready     (push_ready),
        .job           (push_job)
    );

    // Job queue
    fcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Finalizer
    fcm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (pop_valid),
        .job_ready    (pop_ready),
        .job          (pop_job),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_checksum (m_tdata)
    );

endmodule

// ===== verif/fletcher_checksum_mixed_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fletcher checksum core: stream checker
// Watches both stream channels, runs its own copy of the word sums for every
// accepted input transaction and of the finalizer for every closing one, and
// compares each accepted output transaction with the oldest predicted checksum.
// ----------------------------------------------------------------------------
module fletcher_checksum_mixed_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] word, [47:16] stamp
    input  logic        s_tuser,   // [0] word_valid
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] checksum
    output int          checksum_errors,
    output int          checksums_owed
);

    import fcm_pkg::*;

    logic [15:0] low_sum  = '0;
    logic [15:0] high_sum = '0;
    logic [31:0] expected_checksums[$];
    int          error_tally = 0;
    int          owed_tally  = 0;

    assign checksum_errors = error_tally;
    assign checksums_owed  = owed_tally;

    // 16-bit add with end-around carry
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[15:0] + {15'd0, total[16]};
    endfunction

    // Stamp mix followed by the two-multiply fmix32 tail
    function automatic logic [31:0] mix_checksum(input logic [15:0] lo, input logic [15:0] hi,
                                                 input logic [31:0] stamp);
        logic [31:0] r;
        r = {hi, lo} ^ (stamp * STAMP_MULT);
        r = r * MIX_MULT1;
        r = r ^ (r >> MIX_SHIFT1);
        r = r * MIX_MULT2;
        r = r ^ (r >> MIX_SHIFT2);
        return r;
    endfunction

    // Output check first, then fold in the input transaction of this edge
    always @(posedge aclk) begin
        logic [15:0] next_low;
        logic [15:0] next_high;
        logic [31:0] want;
        if (!aresetn) begin
            low_sum  = '0;
            high_sum = '0;
            expected_checksums.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_checksums.size() == 0) begin
                    $error("checksum: none expected, actual %08h", m_tdata);
                    error_tally++;
                end else begin
                    want = expected_checksums.pop_front();
                    if (m_tdata !== want) begin
                        $error("checksum: expected %08h, actual %08h", want, m_tdata);
                        error_tally++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                next_low  = low_sum;
                next_high = high_sum;
                if (s_tuser) begin
                    next_low  = fold_add(low_sum, s_tdata[15:0]);
                    next_high = fold_add(high_sum, next_low);
                end
                // Word on the closing transaction is summed before the mix
                if (s_tlast) begin
                    expected_checksums.push_back(mix_checksum(next_low, next_high,
                                                              s_tdata[47:16]));
                    next_low  = '0;
                    next_high = '0;
                end
                low_sum  = next_low;
                high_sum = next_high;
            end
        end
        owed_tally = expected_checksums.size();
    end

endmodule

// ===== verif/fletcher_checksum_mixed_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fletcher checksum core testbench
// Drives directed and random messages of 16-bit words into the core under
// several sender and receiver idling mixes plus one long output hold-off,
// and leaves prediction and comparison to the stream checker.
// ----------------------------------------------------------------------------
module fletcher_checksum_mixed_core_test;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 360;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [15:0] word, [47:16] stamp
    logic        s_tuser  = 1'b0; // [0] word_valid
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] checksum

    int checksum_errors;
    int checksums_owed;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int hold_tickets      = 0;
    int hold_served       = 0;
    int hold_left         = 0;
    int items_sent        = 0;
    int cycle_count       = 0;

    fletcher_checksum_mixed_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fletcher_checksum_mixed_core_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .checksum_errors (checksum_errors),
        .checksums_owed  (checksums_owed)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: long hold-off on request, otherwise random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_served != hold_tickets) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("fletcher_checksum_mixed_core_test failed");
        $finish;
    end

    // One input transaction, preceded by random idle cycles
    task automatic send_item(input logic [15:0] word, input logic word_valid,
                             input logic last, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, word};
        s_tuser  <= word_valid;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (word_valid || last) items_sent++;
    endtask

    // Word values leaning toward the carry extremes now and then
    function automatic logic [15:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // One message: words with stray idle transactions, closed with or without a word
    task automatic send_message(input int word_count);
        logic close_with_word;
        close_with_word = (word_count > 0) && ($urandom_range(0, 3) != 0);
        for (int i = 0; i < word_count; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(pick_word(), 1'b0, 1'b0, $urandom);
            send_item(pick_word(), 1'b1, close_with_word && (i == word_count - 1), $urandom);
        end
        if (!close_with_word)
            send_item(pick_word(), 1'b0, 1'b1, $urandom);
    endtask

    // Random messages, mostly short, a few long or empty
    task automatic run_messages(input int target);
        int stop_at;
        int sel;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 4)       send_message(0);
            else if (sel < 74) send_message($urandom_range(1, 8));
            else if (sel < 99) send_message($urandom_range(9, 40));
            else               send_message($urandom_range(100, 200));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty messages, extremes, carry folding, closing without a word
        send_item(16'hFFFF, 1'b0, 1'b1, 32'h0000_0000);
        send_item(16'h1234, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(16'h0000, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_item(16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(16'h0000, 1'b1, 1'b1, 32'h0000_0000);
        repeat (4) send_item(16'hFFFF, 1'b1, 1'b0, 32'h0000_0000);
        send_item(16'hFFFF, 1'b1, 1'b1, 32'h8000_0000);
        send_item(16'h0001, 1'b1, 1'b0, 32'h0000_0000);
        send_item(16'hFFFF, 1'b0, 1'b0, 32'h0000_0000);
        send_item(16'h8000, 1'b1, 1'b0, 32'h0000_0000);
        send_item(16'hABCD, 1'b0, 1'b1, 32'h1234_5678);
        send_item(16'hFFFF, 1'b1, 1'b0, 32'h0000_0000);
        send_item(16'h0001, 1'b1, 1'b0, 32'h0000_0000);
        send_item(16'hFFFE, 1'b1, 1'b1, 32'h0000_0001);
        send_item(16'h5A5A, 1'b1, 1'b0, 32'h0000_0000);
        send_item(16'hA5A5, 1'b1, 1'b1, 32'h9E37_79B9);

        // No idling on either side
        run_messages(PHASE_ITEMS);

        // Long output hold-off while short messages keep coming
        hold_tickets = hold_tickets + 1;
        repeat (40) send_message(1);

        // Sender idle most of the time
        sender_idle_pct    = 71;
        receiver_stall_pct = 0;
        run_messages(PHASE_ITEMS);

        // Receiver stalling most of the time
        sender_idle_pct    = 0;
        receiver_stall_pct = 71;
        run_messages(PHASE_ITEMS);

        // Both sides idling
        sender_idle_pct    = 28;
        receiver_stall_pct = 28;
        run_messages(PHASE_ITEMS);

        s_tvalid <= 1'b0;

        // Drain outstanding checksums, then allow for the finalizer latency
        @(posedge aclk);
        while (checksums_owed != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (checksum_errors == 0) begin
            $display("fletcher_checksum_mixed_core_test passed");
        end else begin
            $display("fletcher_checksum_mixed_core_test failed");
        end
        $finish;
    end

endmodule
